### src/gos_pkg.sv
`default_nettype none
package gos_pkg;

  // Bitmap row width and channel width
  localparam int ROW_W = 32;
  localparam int CH_W  = 8;
  localparam int CNT_W = 4;

  localparam logic [ROW_W-1:0] ALPHA_MASK = 32'hff000000;
  localparam logic [ROW_W-1:0] RGB_MASK   = 32'h00ffffff;

  // Request codes
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_READ   = 2'd1,
    REQ_FINISH = 2'd2
  } req_e;

  // Channel being scaled by the shared multiplier
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Window evaluation: neighbor count and outline flags
  typedef struct packed {
    logic [CNT_W-1:0] n_count;
    logic             center_nz;
    logic [ROW_W-1:0] nz_vec;
  } pix_eval_t;

endpackage
`default_nettype wire

### src/gos_row_store.sv
`default_nettype none
module gos_row_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire                        clk_i,
  input  wire                        wr_en_i,
  input  wire  [AW-1:0]              wr_addr_i,
  input  wire  [gos_pkg::ROW_W-1:0]  wr_data_i,
  input  wire                        rd_en_i,
  input  wire  [AW-1:0]              rd_addr_i,
  output logic [gos_pkg::ROW_W-1:0]  rd_data_o
);
  import gos_pkg::*;

  logic [ROW_W-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

### src/gos_window.sv
`default_nettype none
module gos_window (
  input  wire  [gos_pkg::ROW_W-1:0] up_i,
  input  wire  [gos_pkg::ROW_W-1:0] mid_i,
  input  wire  [gos_pkg::ROW_W-1:0] dn_i,
  input  wire  [4:0]                col_i,
  input  wire  [gos_pkg::ROW_W-1:0] color_i,
  output gos_pkg::pix_eval_t        eval_o
);
  import gos_pkg::*;

  logic [ROW_W-1:0] up_sh, mid_sh, dn_sh;
  logic [ROW_W-1:0] neigh4;
  logic             color_nz, rgb_nz;

  always_comb begin
    color_nz = |color_i;
    rgb_nz   = |(color_i & RGB_MASK);

    // 3x3 neighborhood around col_i lands in bits [2:0]
    up_sh  = up_i  >> 5'(col_i - 5'd1);
    mid_sh = mid_i >> 5'(col_i - 5'd1);
    dn_sh  = dn_i  >> 5'(col_i - 5'd1);

    eval_o.n_count = CNT_W'($countones({up_sh[2:0], dn_sh[2:0], mid_sh[2], mid_sh[0]}));
    eval_o.center_nz = mid_sh[1] ? color_nz
                     : (rgb_nz & (up_sh[1] | dn_sh[1] | mid_sh[0] | mid_sh[2]));

    // Whole-row outline flags for the width scan
    neigh4 = up_i | dn_i | (mid_i << 1) | (mid_i >> 1);
    eval_o.nz_vec = (mid_i & {ROW_W{color_nz}}) | (~mid_i & neigh4 & {ROW_W{rgb_nz}});
  end

endmodule
`default_nettype wire

### src/glyph_outline_smoother.sv
`default_nettype none
// Glyph outline smoother.
// Input channel (in_valid_i/in_ready_o) takes one request item: load a bitmap
// row, read one processed RGBA pixel, or finish and report the trimmed width.
// Output channel (out_valid_o/out_ready_i) gives one item per read or finish;
// loads and unknown requests give none. The drawing color is written over the
// APB-style port at addresses 0 to 3 (paddr[2] low); the user must write it
// only while the block is idle; the block does not enforce this. A load in
// range is written to the row memory when accepted. A read fetches three rows
// through the row memory's single registered read port, then scales the red,
// green and blue channels in turn on the shared 8x4 multiplier, then moves
// into the output register. A border or out-of-range read goes straight to
// the output register. A non-space finish streams all GLYPH_HEIGHT rows
// through the memory port, then scans columns right to left, one per cycle.
// The result sits in an output register; a new item is accepted while it waits,
// but the next result is held back until the receiver takes the previous one.
// Reset clears control state and sets the color to all ones; row contents are
// undefined until loaded.
module glyph_outline_smoother #(
  parameter int GLYPH_HEIGHT = 64,
  parameter int GLYPH_WIDTH  = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Request channel
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  req_type_i,
  input  wire  [5:0]  row_index_i,
  input  wire  [4:0]  col_index_i,
  input  wire  [31:0] row_bits_i,
  input  wire         glyph_is_space_i,
  // Result channel
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] pixel_rgba_o,
  output logic [5:0]  glyph_width_o,
  // Configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gos_pkg::*;

  localparam int CW       = $clog2(GLYPH_HEIGHT);
  localparam int SPACE_W  = GLYPH_WIDTH / 3;
  localparam int SCAN_TOP = (GLYPH_WIDTH - 2 < ROW_W) ? GLYPH_WIDTH - 2 : ROW_W - 1;

  function automatic logic [ROW_W-1:0] col_mask_f();
    logic [ROW_W-1:0] m;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (i >= 1) && (i <= GLYPH_WIDTH - 2);
    end
    return m;
  endfunction

  localparam logic [ROW_W-1:0] COL_MASK = col_mask_f();

  state_e state_q, state_d;

  logic [31:0]      color_q;
  logic [CW-1:0]    fetch_row_q, last_q, rrow_q;
  logic             issuing_q, rvalid_q, is_read_q;
  logic [4:0]       col_q;
  logic [ROW_W-1:0] w0_q, w1_q, acc_q;
  logic [CNT_W-1:0] n_q;
  logic             nz_q;
  chan_e            ch_q;
  logic [31:0]      pix_q;
  logic [4:0]       scan_q;
  logic [5:0]       width_q;
  logic             out_valid_q;
  logic [31:0]      out_pix_q;
  logic [5:0]       out_w_q;

  logic             in_fire, cfg_wr, out_free;
  logic             row_interior, col_interior, load_ok;
  logic             fetch_end, rrow_lit, scan_hit;
  logic             mem_wr, mem_rd;
  logic [ROW_W-1:0] rd_data, dn_lit;
  logic [CH_W-1:0]  mul_a;
  logic [CH_W+CNT_W-1:0] mul_p;
  pix_eval_t        eval;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == 1'b0) ? color_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 32'hffffffff;
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      color_q <= pwdata;
    end
  end

  // Request decode
  assign in_fire      = in_valid_i && in_ready_o;
  assign row_interior = int'(row_index_i) >= 1 && int'(row_index_i) <= GLYPH_HEIGHT - 2;
  assign col_interior = int'(col_index_i) >= 1 && int'(col_index_i) <= GLYPH_WIDTH - 2;
  assign load_ok      = int'(row_index_i) < GLYPH_HEIGHT;
  assign out_free     = !out_valid_q || out_ready_i;

  // Row memory
  gos_row_store #(
    .DEPTH (GLYPH_HEIGHT),
    .AW    (CW)
  ) u_rows (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr),
    .wr_addr_i (CW'(row_index_i)),
    .wr_data_i (row_bits_i),
    .rd_en_i   (mem_rd),
    .rd_addr_i (fetch_row_q),
    .rd_data_o (rd_data)
  );

  // Only interior rows and columns can be lit
  assign rrow_lit  = (rrow_q != '0) && (rrow_q != CW'(GLYPH_HEIGHT - 1));
  assign dn_lit    = rrow_lit ? (rd_data & COL_MASK) : '0;
  assign fetch_end = rvalid_q && (rrow_q == last_q);
  assign scan_hit  = acc_q[scan_q];

  gos_window u_window (
    .up_i    (w0_q),
    .mid_i   (w1_q),
    .dn_i    (dn_lit),
    .col_i   (col_q),
    .color_i (color_q),
    .eval_o  (eval)
  );

  // Shared channel multiplier
  always_comb begin
    case (ch_q)
      CH_RED:   mul_a = color_q[23:16];
      CH_GREEN: mul_a = color_q[15:8];
      CH_BLUE:  mul_a = color_q[7:0];
      default:  mul_a = '0;
    endcase
    mul_p = (CH_W+CNT_W)'(mul_a) * (CH_W+CNT_W)'(n_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (req_type_i)
            REQ_READ:   state_d = (row_interior && col_interior) ? ST_FETCH : ST_DONE;
            REQ_FINISH: state_d = glyph_is_space_i ? ST_DONE : ST_FETCH;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: begin
        if (fetch_end) begin
          state_d = is_read_q ? ST_MUL : ST_SCAN;
        end
      end
      ST_MUL: begin
        if (ch_q == CH_BLUE) begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_q == 5'd1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    mem_wr     = in_fire && (req_type_i == REQ_LOAD) && load_ok;
    mem_rd     = (state_q == ST_FETCH) && issuing_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issuing_q   <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= mem_rd;
      if (state_q == ST_IDLE && in_fire && state_d == ST_FETCH) begin
        issuing_q <= 1'b1;
      end else if (mem_rd && fetch_row_q == last_q) begin
        issuing_q <= 1'b0;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        is_read_q   <= (req_type_i == REQ_READ);
        col_q       <= col_index_i;
        acc_q       <= '0;
        pix_q       <= '0;
        scan_q      <= 5'(SCAN_TOP);
        if (req_type_i == REQ_READ) begin
          fetch_row_q <= CW'(row_index_i) - CW'(1);
          last_q      <= CW'(row_index_i) + CW'(1);
          width_q     <= '0;
        end else begin
          fetch_row_q <= '0;
          last_q      <= CW'(GLYPH_HEIGHT - 1);
          width_q     <= 6'(SPACE_W);
        end
      end
      ST_FETCH: begin
        if (mem_rd) begin
          fetch_row_q <= fetch_row_q + CW'(1);
        end
        rrow_q <= fetch_row_q;
        if (rvalid_q) begin
          w0_q <= w1_q;
          w1_q <= dn_lit;
          if (!is_read_q && rrow_q >= CW'(2)) begin
            acc_q <= acc_q | (eval.nz_vec & COL_MASK);
          end
        end
        // Pixel setup only for a read; a finish reports a zero pixel
        if (fetch_end && is_read_q) begin
          n_q   <= eval.n_count;
          nz_q  <= eval.center_nz;
          ch_q  <= CH_RED;
          pix_q <= eval.center_nz ? ALPHA_MASK : '0;
        end
      end
      ST_MUL: begin
        if (nz_q) begin
          case (ch_q)
            CH_RED:   pix_q[23:16] <= mul_p[CH_W+2:3];
            CH_GREEN: pix_q[15:8]  <= mul_p[CH_W+2:3];
            CH_BLUE:  pix_q[7:0]   <= mul_p[CH_W+2:3];
            default:  pix_q        <= pix_q;
          endcase
        end
        case (ch_q)
          CH_RED:   ch_q <= CH_GREEN;
          default:  ch_q <= CH_BLUE;
        endcase
      end
      ST_SCAN: begin
        if (scan_hit) begin
          width_q <= 6'(scan_q) + 6'd1;
        end else if (scan_q == 5'd1) begin
          width_q <= '0;
        end
        scan_q <= scan_q - 5'd1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_pix_q <= pix_q;
          out_w_q   <= width_q;
        end
      end
      default: begin
        rrow_q <= rrow_q;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_rgba_o  = out_pix_q;
  assign glyph_width_o = out_w_q;

  // A fetch always has a row read in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |-> issuing_q || rvalid_q)
    else $error("fetch state without a pending row read");

  // A nonzero pixel is always opaque
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_rgba_o != 32'd0 |-> pixel_rgba_o[31:24] == 8'hff)
    else $error("nonzero pixel without full alpha");

  // Width never exceeds the glyph width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(glyph_width_o) <= GLYPH_WIDTH)
    else $error("glyph width out of range");

  // A space finish completes without touching the row memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req_type_i == REQ_FINISH && glyph_is_space_i |=> state_q == ST_DONE)
    else $error("space finish did not go straight to result");

endmodule
`default_nettype wire
